>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the grid menu debouncer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

>>> rtl/core/gmsd_pkg.sv
// ----------------------------------------------------------------------------
// gmsd_pkg
// Types and constants shared by the grid menu selection debouncer.
// ----------------------------------------------------------------------------
package gmsd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STABLE_CYCLES  = 3'd0,
        CFG_OPTION_COUNT   = 3'd1,
        CFG_FLIP_ROWS      = 3'd2,
        CFG_OPTION_SQUARES = 3'd3,
        CFG_OPTION_IDS     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic        req_type;
        logic [63:0] occupancy;
    } gmsd_in_t;

    typedef struct packed {
        logic       selected;
        logic [2:0] option_index;
        logic [7:0] option_id;
        logic [2:0] square_row;
        logic [2:0] square_col;
    } gmsd_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_scan;
        logic clear_all;
        logic step;
        logic emit;
    } gmsd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic fire;
    } gmsd_status_t;

endpackage

>>> rtl/core/gmsd_ctrl.sv
// ----------------------------------------------------------------------------
// gmsd_ctrl
// Controller: accepts a beat, walks the options one per cycle for a scan, hands
// over the result to the output register.
// ----------------------------------------------------------------------------
module gmsd_ctrl
    import gmsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_req_type,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output gmsd_cmd_t    cmd,
    input  gmsd_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_req_type)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (status.fire)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // The output register is free once its beat has been taken.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/gmsd_datapath.sv
// ----------------------------------------------------------------------------
// gmsd_datapath
// Configuration registers, per-option debouncer state, the shared debouncer
// step and the result and output registers.
// ----------------------------------------------------------------------------
module gmsd_datapath
    import gmsd_pkg::*;
#(
    parameter int MAX_OPTIONS = 8,
    parameter int GRID_ROWS   = 8,
    parameter int GRID_COLS   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  gmsd_in_t              in_data,
    input  gmsd_cmd_t             cmd,
    output gmsd_status_t          status,
    output gmsd_out_t             out_data
);

    localparam int CNT_W = $clog2(MAX_OPTIONS + 1);
    localparam int IDX_W = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
    localparam logic [3:0] MAX_OPT_4 = 4'(MAX_OPTIONS);
    localparam logic signed [4:0] TOP_ROW = 5'(GRID_ROWS - 1);
    localparam logic signed [4:0] ROWS_S = 5'(GRID_ROWS);
    localparam logic [3:0] COLS_4 = 4'(GRID_COLS);

    // Configuration
    logic [7:0]  stable_cycles_reg;
    logic [3:0]  option_count_reg;
    logic        flip_rows_reg;
    logic [47:0] option_squares_reg;
    logic [63:0] option_ids_reg;

    // Debouncer state, one entry per option
    logic [7:0] empty_count_reg [MAX_OPTIONS];
    logic [7:0] present_count_reg [MAX_OPTIONS];
    logic       armed_reg [MAX_OPTIONS];
    logic       latched_reg [MAX_OPTIONS];

    logic [63:0]      occupancy_reg;
    logic [CNT_W-1:0] k_reg;
    gmsd_out_t        res_reg;
    gmsd_out_t        out_data_reg;

    logic [7:0]        need;
    logic [CNT_W-1:0]  count_lim;
    logic [IDX_W-1:0]  idx;
    logic [5:0]        sq;
    logic [2:0]        col;
    logic signed [4:0] row_s;
    logic              on_grid;
    logic              occ;
    logic [7:0]        e_cur;
    logic [7:0]        p_cur;
    logic              a_cur;
    logic              l_cur;
    logic [7:0]        e_next;
    logic [7:0]        p_next;
    logic              a_next;
    logic              l_next;
    logic              fire;

    assign need      = (stable_cycles_reg == 8'd0) ? 8'd1 : stable_cycles_reg;
    assign count_lim = (option_count_reg > MAX_OPT_4) ? CNT_W'(MAX_OPTIONS)
                                                      : CNT_W'(option_count_reg);
    assign idx       = k_reg[IDX_W-1:0];

    assign sq    = option_squares_reg[6*idx +: 6];
    assign col   = sq[2:0];
    assign row_s = flip_rows_reg ? (TOP_ROW - $signed({2'b00, sq[5:3]}))
                                 : $signed({2'b00, sq[5:3]});

    // A mirrored row may fall below zero; such a square reads as empty.
    assign on_grid = (row_s >= 5'sd0) && (row_s < ROWS_S) && ({1'b0, col} < COLS_4);
    assign occ     = on_grid && occupancy_reg[{row_s[2:0], col}];

    assign e_cur = empty_count_reg[idx];
    assign p_cur = present_count_reg[idx];
    assign a_cur = armed_reg[idx];
    assign l_cur = latched_reg[idx];

    always_comb
    begin
        e_next = e_cur;
        p_next = p_cur;
        a_next = a_cur;
        l_next = l_cur;
        fire   = 1'b0;
        if (!occ)
        begin
            if (e_cur < need)
            begin
                e_next = e_cur + 8'd1;
            end
            p_next = 8'd0;
            l_next = 1'b0;
            if (e_next >= need)
            begin
                a_next = 1'b1;
            end
        end
        else
        begin
            e_next = 8'd0;
            if (!a_cur || l_cur)
            begin
                p_next = 8'd0;
            end
            else
            begin
                if (p_cur < need)
                begin
                    p_next = p_cur + 8'd1;
                end
                if (p_next >= need)
                begin
                    a_next = 1'b0;
                    l_next = 1'b1;
                    fire   = 1'b1;
                end
            end
        end
    end

    assign status.done = (k_reg >= count_lim);
    assign status.fire = fire;
    assign out_data    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_cycles_reg  <= 8'd1;
            option_count_reg   <= 4'd0;
            flip_rows_reg      <= 1'b0;
            option_squares_reg <= 48'd0;
            option_ids_reg     <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STABLE_CYCLES:  stable_cycles_reg  <= cfg_wdata[7:0];
                CFG_OPTION_COUNT:   option_count_reg   <= cfg_wdata[3:0];
                CFG_FLIP_ROWS:      flip_rows_reg      <= cfg_wdata[0];
                CFG_OPTION_SQUARES: option_squares_reg <= cfg_wdata[47:0];
                CFG_OPTION_IDS:     option_ids_reg     <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_OPTIONS; i++)
            begin
                empty_count_reg[i]   <= 8'd0;
                present_count_reg[i] <= 8'd0;
                armed_reg[i]         <= 1'b0;
                latched_reg[i]       <= 1'b0;
            end
            k_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            for (int i = 0; i < MAX_OPTIONS; i++)
            begin
                empty_count_reg[i]   <= 8'd0;
                present_count_reg[i] <= 8'd0;
                armed_reg[i]         <= 1'b0;
                latched_reg[i]       <= 1'b0;
            end
        end
        else if (cmd.start_scan)
        begin
            k_reg <= '0;
        end
        else if (cmd.step)
        begin
            empty_count_reg[idx]   <= e_next;
            present_count_reg[idx] <= p_next;
            armed_reg[idx]         <= a_next;
            latched_reg[idx]       <= l_next;
            k_reg                  <= k_reg + CNT_W'(1);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_scan)
        begin
            occupancy_reg <= in_data.occupancy;
        end
        if (cmd.start_scan || cmd.clear_all)
        begin
            res_reg <= '0;
        end
        else if (cmd.step && fire)
        begin
            res_reg.selected     <= 1'b1;
            res_reg.option_index <= 3'(idx);
            res_reg.option_id    <= option_ids_reg[8*idx +: 8];
            res_reg.square_row   <= row_s[2:0];
            res_reg.square_col   <= col;
        end
        if (cmd.emit)
        begin
            out_data_reg <= res_reg;
        end
    end

endmodule

>>> rtl/core/grid_menu_selection_debouncer.sv
// ----------------------------------------------------------------------------
// grid_menu_selection_debouncer
// Debounced selection of menu squares on an occupancy grid.
// ----------------------------------------------------------------------------
// Usage: each input beat is a scan (occupancy bitmap) or a clear command, and
// each produces exactly one output beat. Both channels use valid and stall.
// Registers must be written through cfg_we/cfg_index/cfg_wdata only while the
// block is idle; the block itself does not enforce this. A scan walks the
// active options one per cycle through a single shared debouncer unit,
// stopping at the first option that fires, or gives a beat with no selection
// when none fires; a clear resets the debouncer state and gives a beat with no
// selection. The next input beat can be taken in the cycle after the result
// moves into the output register, so the block takes no new item before the
// last one's result is there. While the receiver stalls, the output beat
// holds; a finished result waits in the datapath and in_stall stays high until
// the output register frees. Reset clears all debouncer state, sets
// stable_cycles to 1 and the other configuration registers to 0, and leaves
// the output channel empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_menu_selection_debouncer
    import gmsd_pkg::*;
#(
    parameter int MAX_OPTIONS = 8,
    parameter int GRID_ROWS   = 8,
    parameter int GRID_COLS   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  gmsd_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output gmsd_out_t             out_data
);

    gmsd_cmd_t    cmd;
    gmsd_status_t status;

    gmsd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_req_type (in_data.req_type),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status)
    );

    gmsd_datapath #(
        .MAX_OPTIONS (MAX_OPTIONS),
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall,
                "input taken while an item is in progress")
    `ASSERT_CLK(a_emit_sets_valid, clk, rst_n, cmd.emit |=> out_valid,
                "emitted result not presented")
    `ASSERT_NEVER(a_step_past_end, clk, rst_n, cmd.step && status.done,
                  "debouncer stepped beyond the active options")

endmodule

>>> bench/gmsd_selection_checker.sv
// ----------------------------------------------------------------------------
// gmsd_selection_checker
// Watches the configuration port and both beat channels of the grid menu
// selection debouncer, predicts each result beat from its own copy of the
// registers and debouncer state, and compares every result field by field.
// ----------------------------------------------------------------------------
module gmsd_selection_checker
    import gmsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  gmsd_in_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  gmsd_out_t             out_data,
    output int                    mismatch_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPTION_SLOTS = 8;
    localparam int GRID_ROWS    = 8;
    localparam int GRID_COLS    = 8;

    logic [7:0]  stable_cycles;
    logic [3:0]  option_count;
    logic        flip_rows;
    logic [47:0] option_squares;
    logic [63:0] option_ids;

    logic [7:0]  empty_cnt [OPTION_SLOTS];
    logic [7:0]  present_cnt [OPTION_SLOTS];
    bit          armed [OPTION_SLOTS];
    bit          latched [OPTION_SLOTS];

    gmsd_out_t   expected_selections [$];

    function automatic void clear_debouncers();
        for (int k = 0; k < OPTION_SLOTS; k++)
        begin
            empty_cnt[k]   = 8'd0;
            present_cnt[k] = 8'd0;
            armed[k]       = 1'b0;
            latched[k]     = 1'b0;
        end
    endfunction

    // Advances one option's debouncer and tells whether it fires.
    function automatic bit step_option(int k, bit occ, logic [7:0] need);
        if (!occ)
        begin
            if (empty_cnt[k] < need)
            begin
                empty_cnt[k]++;
            end
            present_cnt[k] = 8'd0;
            latched[k]     = 1'b0;
            if (empty_cnt[k] >= need)
            begin
                armed[k] = 1'b1;
            end
            return 1'b0;
        end
        empty_cnt[k] = 8'd0;
        if (!armed[k] || latched[k])
        begin
            present_cnt[k] = 8'd0;
            return 1'b0;
        end
        if (present_cnt[k] < need)
        begin
            present_cnt[k]++;
        end
        if (present_cnt[k] >= need)
        begin
            armed[k]   = 1'b0;
            latched[k] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic gmsd_out_t predict_selection(gmsd_in_t beat);
        gmsd_out_t  res;
        logic [7:0] need;
        int         active;
        int         row;
        int         col;
        bit         occ;
        res = '0;
        if (beat.req_type)
        begin
            clear_debouncers();
            return res;
        end
        need   = (stable_cycles == 8'd0) ? 8'd1 : stable_cycles;
        active = (option_count > OPTION_SLOTS) ? OPTION_SLOTS : option_count;
        for (int k = 0; k < active; k++)
        begin
            row = option_squares[6*k+3 +: 3];
            col = option_squares[6*k +: 3];
            if (flip_rows)
            begin
                row = GRID_ROWS - 1 - row;
            end
            occ = 1'b0;
            if (row >= 0 && row < GRID_ROWS && col < GRID_COLS)
            begin
                occ = beat.occupancy[row*8 + col];
            end
            // The first option to fire ends the walk; later options keep their state.
            if (step_option(k, occ, need))
            begin
                res.selected     = 1'b1;
                res.option_index = 3'(k);
                res.option_id    = option_ids[8*k +: 8];
                res.square_row   = 3'(row);
                res.square_col   = 3'(col);
                return res;
            end
        end
        return res;
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gmsd_out_t want;
        if (!rst_n)
        begin
            stable_cycles  = 8'd1;
            option_count   = 4'd0;
            flip_rows      = 1'b0;
            option_squares = '0;
            option_ids     = '0;
            clear_debouncers();
            expected_selections.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_STABLE_CYCLES:  stable_cycles  = cfg_wdata[7:0];
                    CFG_OPTION_COUNT:   option_count   = cfg_wdata[3:0];
                    CFG_FLIP_ROWS:      flip_rows      = cfg_wdata[0];
                    CFG_OPTION_SQUARES: option_squares = cfg_wdata[47:0];
                    CFG_OPTION_IDS:     option_ids     = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_selections.push_back(predict_selection(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_selections.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat, expected none, actual %p", $time, out_data);
                end
                else
                begin
                    want = expected_selections.pop_front();
                    check_field("selected", want.selected, out_data.selected);
                    check_field("option_index", want.option_index, out_data.option_index);
                    check_field("option_id", want.option_id, out_data.option_id);
                    check_field("square_row", want.square_row, out_data.square_row);
                    check_field("square_col", want.square_col, out_data.square_col);
                end
            end
        end
        outstanding = expected_selections.size();
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the grid menu selection debouncer with directed scans and clears,
// then with phases of random configuration and debounce-shaped occupancy
// sequences, with random idling on both channels; the checker judges results.
// ----------------------------------------------------------------------------
module tb;
    import gmsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASES          = 11;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    gmsd_in_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    gmsd_out_t             out_data;
    int                    mismatch_count;
    int                    outstanding;

    int                    cycle_count = 0;
    bit                    quiet_run = 1'b0;
    bit                    hold_request = 1'b0;

    // Current settings as seen by the occupancy generator.
    logic [7:0]            cur_stable;
    logic                  cur_flip;
    logic [47:0]           cur_squares;
    bit                    square_level [8];
    int                    run_left [8];

    grid_menu_selection_debouncer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    gmsd_selection_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold on request, none at the end.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (quiet_run)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Offers a beat and returns at the edge that takes it; valid stays high.
    task automatic send_item(input gmsd_in_t item);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_scan(input logic [63:0] occ);
        send_item(gmsd_in_t'({1'b0, occ}));
    endtask

    task automatic send_clear();
        send_item(gmsd_in_t'({1'b1, $urandom, $urandom}));
    endtask

    task automatic idle_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // Waits until every result has been taken and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_config(input logic [7:0] stable, input logic [3:0] count,
                                  input logic flip, input logic [47:0] squares,
                                  input logic [63:0] ids);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STABLE_CYCLES;
        cfg_wdata <= 64'(stable);
        @(posedge clk);
        cfg_index <= CFG_OPTION_COUNT;
        cfg_wdata <= 64'(count);
        @(posedge clk);
        cfg_index <= CFG_FLIP_ROWS;
        cfg_wdata <= 64'(flip);
        @(posedge clk);
        cfg_index <= CFG_OPTION_SQUARES;
        cfg_wdata <= 64'(squares);
        @(posedge clk);
        cfg_index <= CFG_OPTION_IDS;
        cfg_wdata <= ids;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_stable  = stable;
        cur_flip    = flip;
        cur_squares = squares;
        for (int k = 0; k < 8; k++)
        begin
            square_level[k] = 1'($urandom_range(0, 1));
            run_left[k]     = 0;
        end
    endtask

    // Run lengths cluster around the stable count so that arming and firing
    // are reached often, with short runs breaking sequences off.
    function automatic int run_length();
        int need;
        need = (cur_stable == 8'd0) ? 1 : cur_stable;
        case ($urandom_range(0, 3))
            0: return (need > 1) ? need - 1 : 1;
            1: return need;
            2: return need + 1;
            default: return $urandom_range(1, 2 * need + 1);
        endcase
    endfunction

    function automatic gmsd_in_t next_random_item();
        gmsd_in_t item;
        int       pick;
        int       row;
        int       col;
        pick           = $urandom_range(0, 99);
        item.req_type  = (pick < 4);
        item.occupancy = {$urandom, $urandom};
        // Most scans carry each option square's bit from its own run pattern;
        // the remainder are pure noise.
        if (pick >= 14)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (run_left[k] == 0)
                begin
                    square_level[k] = !square_level[k];
                    run_left[k]     = run_length();
                end
                run_left[k]--;
                row = cur_squares[6*k+3 +: 3];
                col = cur_squares[6*k +: 3];
                if (cur_flip)
                begin
                    row = 7 - row;
                end
                item.occupancy[row*8 + col] = square_level[k];
            end
        end
        return item;
    endfunction

    initial
    begin
        logic [7:0]  stable;
        logic [3:0]  count;
        logic        flip;
        logic [47:0] squares;
        logic [63:0] ids;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // No options after reset: scans and clears report nothing.
        send_scan('1);
        send_scan('0);
        send_clear();
        settle();

        // Options on the diagonal; a stable count of zero acts as one.
        program_config(8'd0, 4'd8, 1'b0,
                       48'b111111_110110_101101_100100_011011_010010_001001_000000,
                       64'hFF66_5544_3322_1100);
        send_scan('0);
        send_scan(64'd1 << 27);
        send_scan('1);
        send_scan('1);
        send_scan('1);
        send_clear();
        send_scan('1);
        send_scan('0);
        send_scan(64'h8000_0000_0000_0000);
        settle();

        // Mirrored rows and an option count above the number of slots.
        program_config(8'd2, 4'd15, 1'b1, 48'd5, 64'h0000_0000_0000_0042);
        send_scan('0);
        send_scan('0);
        send_scan(64'd1 << 61);
        send_scan(64'd1 << 61);
        send_scan(64'h5555_5555_5555_5555);
        send_scan(64'hAAAA_AAAA_AAAA_AAAA);
        send_clear();
        send_scan('1);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            stable  = 8'($urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0)
            begin
                stable = 8'($urandom_range(4, 8));
            end
            count   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
            flip    = 1'($urandom_range(0, 1));
            squares = 48'({$urandom, $urandom});
            if ($urandom_range(0, 2) == 0)
            begin
                // Few distinct squares, so that options share a square.
                for (int k = 0; k < 8; k++)
                begin
                    squares[6*k +: 6] = 6'($urandom_range(0, 3) * 9);
                end
            end
            ids = {$urandom, $urandom};
            case (p)
                0:
                begin
                    stable = 8'd1;
                    count  = 4'd8;
                    flip   = 1'b0;
                end
                1:
                begin
                    stable = 8'd0;
                    count  = 4'd15;
                    flip   = 1'b1;
                    ids    = '0;
                end
                2:
                begin
                    stable  = 8'd3;
                    count   = 4'd8;
                    squares = '1;
                    ids     = '1;
                end
                3:
                begin
                    stable = 8'd255;
                    count  = 4'd2;
                end
                4:
                begin
                    count = 4'd0;
                end
                default: ;
            endcase
            quiet_run = (p == PHASES - 1);
            program_config(stable, count, flip, squares, ids);
            if (p == 2)
            begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (!quiet_run && $urandom_range(0, 3) == 0)
                begin
                    idle_gap();
                end
                send_item(next_random_item());
            end
            settle();
        end

        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
